@@ hw/rtl/qdec_pkg.sv @@
// Shared types and constants for the quadrature decoder with acceleration.
// Holds the configuration register map, the transition table and the step result type.
// No dependencies.
package qdec_pkg;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 16;
    localparam int DELTA_W     = 10;

    localparam logic [CFG_INDEX_W-1:0] CFG_HIGH_RESOLUTION = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_FAST_WINDOW_MS  = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_FAST_MULTIPLIER = 2'd2;

    typedef struct packed {
        logic        high_resolution;
        logic [15:0] fast_window_ms;
        logic [7:0]  fast_multiplier;
    } cfg_t;

    typedef struct packed {
        logic signed [DELTA_W-1:0] delta;
        logic                      event_hit;
    } step_t;

    // Indexed by {prev_a, prev_b, a, b}.
    localparam logic signed [2:0] HR_TABLE [16] = '{
        3'sd0,  3'sd1,  -3'sd1, 3'sd2,
        -3'sd1, 3'sd0,  -3'sd2, 3'sd1,
        3'sd1,  -3'sd2, 3'sd0,  -3'sd1,
        3'sd2,  -3'sd1, 3'sd1,  3'sd0
    };

endpackage

@@ hw/rtl/quadrature_decoder_with_acceleration.sv @@
// Top level of the quadrature decoder with speed-dependent acceleration.
// Depends on qdec_pkg, qdec_cfg and qdec_step.
//
// Channel  | Transfer when           | Payload
// ---------+-------------------------+------------------------------
// in       | in_valid && !in_stall   | chan_a, chan_b, now_ms
// out      | out_valid && !out_stall | delta
// cfg      | cfg_valid && cfg_ready  | cfg_index, cfg_data
//
// One sample is accepted every cycle while the input does not stall; its delta passes
// through the input register and then the output register before it can transfer out.
// The decoder state and the timestamp of the last counted event update as a sample
// leaves the input register, so each sample sees the state left by the one before.
// Reset sets the previous AB state to 11, the event timestamp to zero and the
// registers to their defaults. A stall on a valid output holds the output and a full input register in place.
module quadrature_decoder_with_acceleration (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    in_valid,
    output logic                                    in_stall,
    input  logic                                    chan_a,
    input  logic                                    chan_b,
    input  logic [31:0]                             now_ms,
    output logic                                    out_valid,
    input  logic                                    out_stall,
    output logic signed [qdec_pkg::DELTA_W-1:0]     delta,
    input  logic                                    cfg_valid,
    output logic                                    cfg_ready,
    input  logic [qdec_pkg::CFG_INDEX_W-1:0]        cfg_index,
    input  logic [qdec_pkg::CFG_DATA_W-1:0]         cfg_data
);

    qdec_pkg::cfg_t  cfg;
    qdec_pkg::step_t result;

    logic                               in_valid_reg;
    logic                               chan_a_reg;
    logic                               chan_b_reg;
    logic [31:0]                        now_ms_reg;
    logic                               prev_a_reg;
    logic                               prev_b_reg;
    logic [31:0]                        last_event_reg;
    logic                               out_valid_reg;
    logic signed [qdec_pkg::DELTA_W-1:0] delta_reg;
    logic                               advance;
    logic                               accept;

    assign cfg_ready = 1'b1;

    qdec_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    qdec_step u_step (
        .cfg           (cfg),
        .prev_a        (prev_a_reg),
        .prev_b        (prev_b_reg),
        .last_event_ms (last_event_reg),
        .chan_a        (chan_a_reg),
        .chan_b        (chan_b_reg),
        .now_ms        (now_ms_reg),
        .result        (result)
    );

    assign advance  = in_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = in_valid_reg && !advance;
    assign accept   = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            prev_a_reg     <= 1'b1;
            prev_b_reg     <= 1'b1;
            last_event_reg <= 32'd0;
        end
        else
        begin
            if (accept || advance)
            begin
                in_valid_reg <= accept;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
                prev_a_reg    <= chan_a_reg;
                prev_b_reg    <= chan_b_reg;
                if (result.event_hit)
                begin
                    last_event_reg <= now_ms_reg;
                end
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            chan_a_reg <= chan_a;
            chan_b_reg <= chan_b;
            now_ms_reg <= now_ms;
        end
        if (advance)
        begin
            delta_reg <= result.delta;
        end
    end

    assign out_valid = out_valid_reg;
    assign delta     = delta_reg;

endmodule

@@ hw/rtl/qdec_cfg.sv @@
// Configuration register file of the quadrature decoder.
// Depends on qdec_pkg for the register map and the cfg_t type.
module qdec_cfg (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_valid,
    input  logic [qdec_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [qdec_pkg::CFG_DATA_W-1:0]     cfg_data,
    output qdec_pkg::cfg_t                      cfg
);

    qdec_pkg::cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.high_resolution <= 1'b0;
            cfg_reg.fast_window_ms  <= 16'd0;
            cfg_reg.fast_multiplier <= 8'd1;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                qdec_pkg::CFG_HIGH_RESOLUTION: cfg_reg.high_resolution <= cfg_data[0];
                qdec_pkg::CFG_FAST_WINDOW_MS:  cfg_reg.fast_window_ms  <= cfg_data;
                qdec_pkg::CFG_FAST_MULTIPLIER: cfg_reg.fast_multiplier <= cfg_data[7:0];
                default:                       cfg_reg <= cfg_reg;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

@@ hw/rtl/qdec_step.sv @@
// Per-sample decode step: transition lookup, window check and speed multiply.
// Depends on qdec_pkg for the transition table and the cfg_t and step_t types.
module qdec_step (
    input  qdec_pkg::cfg_t  cfg,
    input  logic            prev_a,
    input  logic            prev_b,
    input  logic [31:0]     last_event_ms,
    input  logic            chan_a,
    input  logic            chan_b,
    input  logic [31:0]     now_ms,
    output qdec_pkg::step_t result
);

    logic signed [2:0]  raw_delta;
    logic               check;
    logic [31:0]        elapsed;
    logic               fast;
    logic signed [11:0] product;

    always_comb
    begin
        if (cfg.high_resolution)
        begin
            raw_delta = qdec_pkg::HR_TABLE[{prev_a, prev_b, chan_a, chan_b}];
            check     = chan_a && chan_b;
        end
        else
        begin
            raw_delta = (prev_a && !chan_a) ? (chan_b ? -3'sd1 : 3'sd1) : 3'sd0;
            check     = 1'b1;
        end
    end

    // A negative signed difference counts as inside the window.
    assign elapsed = now_ms - last_event_ms;
    assign fast    = elapsed[31] || (elapsed <= {16'd0, cfg.fast_window_ms});
    assign product = raw_delta * $signed({1'b0, cfg.fast_multiplier});

    always_comb
    begin
        result.event_hit = check && (raw_delta != 3'sd0);
        if (result.event_hit && fast)
        begin
            result.delta = product[qdec_pkg::DELTA_W-1:0];
        end
        else
        begin
            result.delta = {{(qdec_pkg::DELTA_W-3){raw_delta[2]}}, raw_delta};
        end
    end

endmodule

@@ hw/rtl/qdec_checker.sv @@
// Port-level checker for the quadrature decoder, attached to the top level by bind.
// Depends on qdec_pkg for the delta width.
module qdec_checker (
    input logic                                 clk,
    input logic                                 rst_n,
    input logic                                 in_valid,
    input logic                                 in_stall,
    input logic                                 out_valid,
    input logic                                 out_stall,
    input logic signed [qdec_pkg::DELTA_W-1:0]  delta,
    input logic                                 cfg_ready
);

    // A held result keeps its value while the receiver stalls.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(delta))
        else $error("output transfer changed while stalled");

    // The input only stalls when a result is waiting on a stalled output.
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("input stalled without output back-pressure");

    // An accepted sample reaches the output once the output is free.
    a_flow: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) ##1 !out_stall |=> out_valid)
        else $error("accepted sample did not reach the output");

    // The delta never leaves the range of the multiplied transition values, and the configuration port stays ready.
    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ($signed(delta) >= -510) && ($signed(delta) <= 510) && cfg_ready)
        else $error("delta out of range or configuration port not ready");

endmodule

bind quadrature_decoder_with_acceleration qdec_checker u_qdec_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .delta     (delta),
    .cfg_ready (cfg_ready)
);
